>>> rtl/core/swmm_pkg.sv
// ============================================================================
// swmm_pkg
// Shared constants, types and register codes of the sliding window min/max.
// ============================================================================
`default_nettype none

package swmm_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int AGE_W        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
    localparam int CFG_W        = 7;
    localparam int SPAN_W       = CFG_W + CNT_W;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam logic [CFG_W-1:0] WL_RESET = CFG_W'(16);
    localparam logic [CFG_W-1:0] MC_RESET = CFG_W'(1);

    typedef enum logic [1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_MIN_COUNT     = 2'd1,
        REG_MAX_MODE      = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] window_length;
        logic [CFG_W-1:0] min_count;
        logic             max_mode;
    } t_cfg;

    // running extreme handed from cell to cell
    typedef struct packed {
        logic                           valid;
        logic                           found;
        logic signed [SAMPLE_WIDTH-1:0] best;
        logic [AGE_W-1:0]               age;
        logic [CNT_W-1:0]               count;
    } t_token;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] extreme;
        logic [AGE_W-1:0]               extreme_age;
        logic                           result_valid;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/swmm_if.sv
// ============================================================================
// swmm_if
// Valid/ready channels for input samples and window results.
// ============================================================================
`default_nettype none

interface swmm_in_if import swmm_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           sample_present;

    modport source (output valid, output sample, output sample_present, input ready);
    modport sink   (input valid, input sample, input sample_present, output ready);
endinterface

interface swmm_out_if import swmm_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] extreme;
    logic [AGE_W-1:0]               extreme_age;
    logic                           result_valid;

    modport source (output valid, output extreme, output extreme_age, output result_valid,
                    input ready);
    modport sink   (input valid, input extreme, input extreme_age, input result_valid,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/swmm_cfg.sv
// ============================================================================
// swmm_cfg
// APB register file: window length, minimum count and min/max mode.
// ============================================================================
`default_nettype none

module swmm_cfg import swmm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length <= WL_RESET;
            r_cfg.min_count     <= MC_RESET;
            r_cfg.max_mode      <= 1'b0;
        end else if (w_wr) begin
            case (paddr[ADDR_W-1:2])
                REG_WINDOW_LENGTH: r_cfg.window_length <= pwdata[CFG_W-1:0];
                REG_MIN_COUNT:     r_cfg.min_count     <= pwdata[CFG_W-1:0];
                REG_MAX_MODE:      r_cfg.max_mode      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_WINDOW_LENGTH: prdata = DATA_W'(r_cfg.window_length);
            REG_MIN_COUNT:     prdata = DATA_W'(r_cfg.min_count);
            REG_MAX_MODE:      prdata = DATA_W'(r_cfg.max_mode);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/swmm_cell.sv
// ============================================================================
// swmm_cell
// One history slot of the chain plus one step of the extreme scan.
// ============================================================================
`default_nettype none

module swmm_cell import swmm_pkg::*; (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_shift,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_value,
    input  wire logic                           i_present,
    output logic signed      [SAMPLE_WIDTH-1:0] o_value,
    output logic                                o_present,
    input  wire logic [AGE_W-1:0]               i_idx,
    input  wire logic [AGE_W-1:0]               i_last,
    input  wire logic                           i_max_mode,
    input  wire t_token                         i_tok,
    output t_token                              o_tok,
    output logic                                o_fin
);

    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic                           r_present;
    t_token                         r_tok;
    t_token                         n_tok;
    logic                           r_fin;
    logic                           n_fin;
    logic                           w_use;
    logic                           w_better;

    assign o_value   = r_value;
    assign o_present = r_present;
    assign o_tok     = r_tok;
    assign o_fin     = r_fin;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value   <= i_value;
            r_present <= i_present;
        end
    end

    // scanning newest to oldest: only a strictly better sample replaces
    always_comb begin
        w_use    = i_tok.valid && r_present;
        w_better = !i_tok.found ||
                   (i_max_mode ? (r_value > i_tok.best) : (r_value < i_tok.best));
        n_tok       = i_tok;
        n_tok.valid = i_tok.valid && (i_idx != i_last);
        n_tok.found = i_tok.found || w_use;
        n_tok.count = i_tok.count + CNT_W'(w_use);
        if (w_use && w_better) begin
            n_tok.best = r_value;
            n_tok.age  = i_idx;
        end
        n_fin = i_tok.valid && (i_idx == i_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_fin       <= 1'b0;
        end else begin
            r_tok <= n_tok;
            r_fin <= n_fin;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sliding_window_min_max_argext.sv
// A sample word is taken only while idle. The scan token then walks the cell chain
// one cell per cycle across the window span, the window length limited to the
// samples seen so far (1..64), and the result word is registered. No new word is
// taken until that result is loaded; an output word still waiting blocks it.
// Reset: synchronous, active low; history is not reset, fill level and scan clear,
// registers return to window 16, min count 1, minimum mode.
// ============================================================================
// sliding_window_min_max_argext
// Sliding window minimum/maximum with age of its newest occurrence.
// ============================================================================
`default_nettype none

module sliding_window_min_max_argext import swmm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    swmm_in_if.sink                i_in,
    swmm_out_if.source             o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    t_cfg   w_cfg;
    t_state r_state;
    logic   [CNT_W-1:0] r_fill;
    logic   [CNT_W-1:0] w_fill_next;
    logic   [AGE_W-1:0] r_last;
    logic   [SPAN_W-1:0] w_span;
    logic   r_start;
    logic   w_accept;
    logic   w_out_free;
    logic   w_out_load;
    t_result r_hold;
    t_result r_out;
    logic   r_out_valid;
    t_result w_res;
    t_token  w_tok_head;
    t_token  w_fin_tok;
    logic    w_fin_any;

    logic signed [SAMPLE_WIDTH-1:0] w_val   [WINDOW_MAX];
    logic                           w_pres  [WINDOW_MAX];
    t_token                         w_tok_in  [WINDOW_MAX];
    t_token                         w_tok_out [WINDOW_MAX];
    logic                           w_fin   [WINDOW_MAX];

    swmm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_out_load = w_out_free &&
                        (((r_state == ST_SCAN) && w_fin_any) || (r_state == ST_HOLD));

    always_comb begin
        w_tok_head       = '0;
        w_tok_head.valid = r_start;
    end

    assign w_val[0]  = i_in.sample;
    assign w_pres[0] = i_in.sample_present;

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign w_tok_in[i] = w_tok_head;
        end else begin : g_body
            assign w_tok_in[i] = w_tok_out[i-1];
        end
        if (i < WINDOW_MAX - 1) begin : g_mid
            swmm_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (w_accept),
                .i_value    (w_val[i]),
                .i_present  (w_pres[i]),
                .o_value    (w_val[i+1]),
                .o_present  (w_pres[i+1]),
                .i_idx      (AGE_W'(i)),
                .i_last     (r_last),
                .i_max_mode (w_cfg.max_mode),
                .i_tok      (w_tok_in[i]),
                .o_tok      (w_tok_out[i]),
                .o_fin      (w_fin[i])
            );
        end else begin : g_tail
            swmm_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (w_accept),
                .i_value    (w_val[i]),
                .i_present  (w_pres[i]),
                .o_value    (),
                .o_present  (),
                .i_idx      (AGE_W'(i)),
                .i_last     (r_last),
                .i_max_mode (w_cfg.max_mode),
                .i_tok      (w_tok_in[i]),
                .o_tok      (w_tok_out[i]),
                .o_fin      (w_fin[i])
            );
        end
    end

    // only one token is in flight, so the finished one is picked by AND-OR
    always_comb begin
        w_fin_tok = '0;
        w_fin_any = 1'b0;
        for (int k = 0; k < WINDOW_MAX; k++) begin
            w_fin_any = w_fin_any | w_fin[k];
            w_fin_tok = w_fin_tok | ({$bits(t_token){w_fin[k]}} & w_tok_out[k]);
        end
    end

    always_comb begin
        w_res.result_valid = w_fin_tok.found &&
            ({{CFG_W{1'b0}}, w_fin_tok.count} >= {{CNT_W{1'b0}}, w_cfg.min_count});
        w_res.extreme      = w_res.result_valid ? w_fin_tok.best : '0;
        w_res.extreme_age  = w_res.result_valid ? w_fin_tok.age : '0;
    end

    always_comb begin
        w_fill_next = (r_fill == CNT_W'(WINDOW_MAX)) ? r_fill : r_fill + CNT_W'(1);
        w_span      = SPAN_W'(w_cfg.window_length);
        if (w_span == '0) begin
            w_span = SPAN_W'(1);
        end
        if (w_span > SPAN_W'(WINDOW_MAX)) begin
            w_span = SPAN_W'(WINDOW_MAX);
        end
        if (w_span > SPAN_W'(w_fill_next)) begin
            w_span = SPAN_W'(w_fill_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_fill  <= w_fill_next;
                        r_last  <= AGE_W'(w_span - SPAN_W'(1));
                        r_start <= 1'b1;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_fin_any) begin
                        if (w_out_free) begin
                            r_out   <= w_res;
                            r_state <= ST_IDLE;
                        end else begin
                            r_hold  <= w_res;
                            r_state <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD: begin
                    if (w_out_free) begin
                        r_out   <= r_hold;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.extreme      = r_out.extreme;
    assign o_out.extreme_age  = r_out.extreme_age;
    assign o_out.result_valid = r_out.result_valid;

endmodule

`default_nettype wire

>>> rtl/core/swmm_checker.sv
// ============================================================================
// swmm_checker
// Port-level checks of the sliding window min/max, bound to the top level.
// ============================================================================
`default_nettype none

module swmm_checker import swmm_pkg::*; (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic signed [SAMPLE_WIDTH-1:0] i_extreme,
    input wire logic [AGE_W-1:0]               i_extreme_age,
    input wire logic                           i_result_valid
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_extreme) &&
            $stable(i_extreme_age) && $stable(i_result_valid))
        else $error("result word dropped or changed while stalled");

    a_zero_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_result_valid |-> i_extreme == '0 && i_extreme_age == '0)
        else $error("missing result carries non-zero fields");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second word taken while scan in progress");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after accept");

endmodule

bind sliding_window_min_max_argext swmm_checker u_swmm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_extreme      (o_out.extreme),
    .i_extreme_age  (o_out.extreme_age),
    .i_result_valid (o_out.result_valid)
);

`default_nettype wire

>>> verif/swmm_window_checker.sv
// ============================================================================
// swmm_window_checker
// Watches the sample and result channels and the register port of the sliding
// window min/max block, predicts each result word from its own copy of the
// sample ring and registers, and compares every field in arrival order.
// ============================================================================

module swmm_window_checker import swmm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    swmm_in_if                i_in_mon,
    swmm_out_if               i_out_mon,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output int unsigned       o_fail_count,
    output int unsigned       o_pending
);

    logic signed [SAMPLE_WIDTH-1:0] ring_val [WINDOW_MAX];
    logic                           ring_pres [WINDOW_MAX];
    int unsigned                    next_slot;
    int unsigned                    filled;
    logic [CFG_W-1:0]               cfg_window;
    logic [CFG_W-1:0]               cfg_min;
    logic                           cfg_max;
    t_result                        expected_q [$];
    int unsigned                    words_out;

    task automatic report_fault(input string msg);
        $display("[%0t] window check, word %0d: %s", $time, words_out, msg);
        o_fail_count++;
    endtask

    // stores the word in the ring and scans the window newest first
    function automatic t_result window_extreme(input logic signed [SAMPLE_WIDTH-1:0] smp,
                                               input logic pres);
        int unsigned cur, span, slot, hits, best_age, a;
        bit have;
        logic signed [SAMPLE_WIDTH-1:0] best;
        t_result r;
        cur = next_slot;
        ring_val[cur]  = smp;
        ring_pres[cur] = pres;
        next_slot = (cur + 1) % WINDOW_MAX;
        if (filled < WINDOW_MAX) filled++;
        span = cfg_window;
        if (span < 1) span = 1;
        if (span > WINDOW_MAX) span = WINDOW_MAX;
        if (span > filled) span = filled;
        have = 1'b0;
        hits = 0;
        best = '0;
        best_age = 0;
        for (a = 0; a < span; a++) begin
            slot = (cur + WINDOW_MAX - a) % WINDOW_MAX;
            if (ring_pres[slot]) begin
                hits++;
                // strictly better only, so ties keep the newest
                if (!have || (cfg_max ? ring_val[slot] > best : ring_val[slot] < best)) begin
                    have = 1'b1;
                    best = ring_val[slot];
                    best_age = a;
                end
            end
        end
        r = '0;
        if (have && hits >= cfg_min) begin
            r.extreme      = best;
            r.extreme_age  = best_age[AGE_W-1:0];
            r.result_valid = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result got, want;
        if (!i_rst_n) begin
            next_slot    = 0;
            filled       = 0;
            cfg_window   = WL_RESET;
            cfg_min      = MC_RESET;
            cfg_max      = 1'b0;
            words_out    = 0;
            o_fail_count = 0;
            expected_q.delete();
            o_pending    <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[ADDR_W-1:2]))
                    REG_WINDOW_LENGTH: cfg_window = i_pwdata[CFG_W-1:0];
                    REG_MIN_COUNT:     cfg_min    = i_pwdata[CFG_W-1:0];
                    REG_MAX_MODE:      cfg_max    = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.extreme      = i_out_mon.extreme;
                got.extreme_age  = i_out_mon.extreme_age;
                got.result_valid = i_out_mon.result_valid;
                if (expected_q.size() == 0) begin
                    report_fault("result word with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    if (got.extreme !== want.extreme)
                        report_fault($sformatf("extreme %0d, expected %0d",
                                               got.extreme, want.extreme));
                    if (got.extreme_age !== want.extreme_age)
                        report_fault($sformatf("extreme_age %0d, expected %0d",
                                               got.extreme_age, want.extreme_age));
                    if (got.result_valid !== want.result_valid)
                        report_fault($sformatf("result_valid %0b, expected %0b",
                                               got.result_valid, want.result_valid));
                end
                words_out++;
            end
            if (i_in_mon.valid && i_in_mon.ready)
                expected_q.insert(expected_q.size(),
                                  window_extreme(i_in_mon.sample, i_in_mon.sample_present));
            o_pending <= expected_q.size();
        end
    end

endmodule

>>> verif/testbench.sv
// ============================================================================
// testbench
// Drives samples and register writes into the sliding window min/max block
// with random idling and a long result hold-off; the checker beside the block
// predicts and compares every result word.
// ============================================================================

module testbench;
    import swmm_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int IDLE_PCT      = 14;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_WORDS   = 75;
    localparam int RANDOM_PHASES = 8;
    localparam int SETTLE_CYCLES = 80;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic              pready;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    int unsigned       fail_count;
    int unsigned       pending;
    int unsigned       quiet_cycles = 0;
    int unsigned       present_pct;
    bit                calm;
    bit                hold_req;

    swmm_in_if  in_ch();
    swmm_out_if out_ch();

    sliding_window_min_max_argext i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    swmm_window_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic logic [SAMPLE_WIDTH-1:0] random_sample();
        case ($urandom_range(3))
            0:       return SAMPLE_WIDTH'($urandom_range(8)) - SAMPLE_WIDTH'(4);
            1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic push_word(input logic [SAMPLE_WIDTH-1:0] value, input logic present);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.sample         <= value;
        in_ch.sample_present <= present;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] wl, input logic [CFG_W-1:0] mc,
                              input logic mm);
        drain();
        apb_write(REG_WINDOW_LENGTH, DATA_W'(wl));
        apb_write(REG_MIN_COUNT, DATA_W'(mc));
        apb_write(REG_MAX_MODE, DATA_W'(mm));
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] wl, mc;
        int unsigned      phase;
        in_ch.valid          = 1'b0;
        in_ch.sample         = '0;
        in_ch.sample_present = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        present_pct = 80;
        i_rst_n     = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: window 16, minimum; empty start, extremes, ties
        push_word(32'h0000_0000, 1'b0);
        push_word(32'h7FFF_FFFF, 1'b1);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1);
        push_word(32'h0000_0000, 1'b1);
        push_word(32'hFFFF_FFFF, 1'b1);
        push_word(32'h8000_0000, 1'b1);
        push_word(32'h8000_0000, 1'b1);
        // single word window, maximum
        set_config(7'd1, 7'd1, 1'b1);
        push_word(32'h0000_0005, 1'b1);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'h7FFF_FFFF, 1'b1);
        push_word(32'h8000_0000, 1'b1);
        // widest window, count out of reach
        set_config(7'd64, 7'd64, 1'b0);
        push_word(32'h0000_0001, 1'b1);
        push_word(32'h8000_0000, 1'b1);
        push_word(32'h7FFF_FFFF, 1'b1);
        // zero window and zero count
        set_config(7'd0, 7'd0, 1'b1);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'h0000_0003, 1'b1);
        // window above the ring: older words come back in
        set_config(7'd127, 7'd2, 1'b1);
        push_word(32'hFFFF_FFF9, 1'b1);
        push_word(32'hFFFF_FFF9, 1'b0);
        // count above window
        set_config(7'd2, 7'd5, 1'b0);
        push_word(32'h0000_0001, 1'b1);
        push_word(32'h0000_0002, 1'b1);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(5))
                0:       wl = 7'd64;
                1:       wl = $urandom_range(1) ? 7'd0 : 7'd127;
                default: wl = CFG_W'($urandom_range(1, 12));
            endcase
            if (phase == RANDOM_PHASES - 1) wl = 7'd64;
            mc = ($urandom_range(4) == 0) ? CFG_W'($urandom_range(127))
                                          : CFG_W'($urandom_range(0, 5));
            set_config(wl, mc, 1'($urandom_range(1)));
            present_pct = (phase % 3 == 1) ? 40 : 90;
            calm = (phase == 2);
            if (phase == 4) hold_req = 1'b1;
            repeat (PHASE_WORDS)
                push_word(random_sample(), 1'($urandom_range(99) < present_pct));
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
